>>> src/ptsc_pkg.sv
// shared widths, reset values, codes and divider link types for the pulse time sync corrector
`default_nettype none

package ptsc_pkg;

   localparam int TIME_W      = 44;
   localparam int CORR_W      = TIME_W + 1;
   localparam int SUM_W       = 24;
   localparam int THR_W       = 16;
   localparam int LIMIT_W     = 4;
   localparam int OUTCOME_W   = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = THR_W;
   localparam int DIV_CNT_W   = $clog2(SUM_W);

   localparam logic [THR_W-1:0]   STEP_THR_RESET   = THR_W'(5000);
   localparam logic [THR_W-1:0]   TOLERANCE_RESET  = THR_W'(200);
   localparam logic [LIMIT_W-1:0] MISS_LIMIT_RESET = LIMIT_W'(5);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_THR   = 2'd0,
      CSR_TOLERANCE  = 2'd1,
      CSR_MISS_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_NONE       = 3'd0,
      OUT_IN_TOL     = 3'd1,
      OUT_ACCUM      = 3'd2,
      OUT_LARGE_STEP = 3'd3,
      OUT_AVG_STEP   = 3'd4
   } outcome_type;

   typedef struct packed {
      logic                     start;
      logic signed [SUM_W-1:0]  dividend;
      logic [LIMIT_W-1:0]       divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [SUM_W-1:0]  quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> src/ptsc_req_if.sv
// input channel: pulse and sync events
`default_nettype none

interface ptsc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [ptsc_pkg::TIME_W-1:0]   local_ms;
   logic [ptsc_pkg::TIME_W-1:0]   reference_ms;

   modport source (output valid, output action, output local_ms, output reference_ms,
                   input ready);
   modport sink   (input valid, input action, input local_ms, input reference_ms,
                   output ready);
endinterface

`default_nettype wire

>>> src/ptsc_rsp_if.sv
// result channel: clock corrections
`default_nettype none

interface ptsc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                set_clock;
   logic [ptsc_pkg::TIME_W-1:0]         new_time_ms;
   logic signed [ptsc_pkg::CORR_W-1:0]  correction_ms;
   logic [ptsc_pkg::OUTCOME_W-1:0]      outcome;

   modport source (output valid, output set_clock, output new_time_ms,
                   output correction_ms, output outcome, input ready);
   modport sink   (input valid, input set_clock, input new_time_ms,
                   input correction_ms, input outcome, output ready);
endinterface

`default_nettype wire

>>> src/ptsc_csr_if.sv
// configuration write channel
`default_nettype none

interface ptsc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ptsc_pkg::CSR_INDEX_W-1:0]   index;
   logic [ptsc_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/ptsc_div.sv
// serial restoring divider: signed sum by unsigned miss count, truncating toward zero
`default_nettype none

module ptsc_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ptsc_pkg::div_req_type req,
   output ptsc_pkg::div_rsp_type      rsp
);

   localparam int SumW  = ptsc_pkg::SUM_W;
   localparam int LimW  = ptsc_pkg::LIMIT_W;
   localparam int CntW  = ptsc_pkg::DIV_CNT_W;
   localparam logic [CntW-1:0] LastStep = CntW'(SumW - 1);

   logic                busy_ff;
   logic                done_ff;
   logic                neg_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [LimW-1:0]     rem_ff;
   logic [LimW-1:0]     div_ff;
   logic [SumW-1:0]     quo_ff;

   logic [SumW-1:0]     mag_in;
   logic [LimW:0]       rem_shift;
   logic                fits;
   logic [LimW:0]       rem_diff;
   logic [LimW-1:0]     rem_in;

   always_comb begin
      mag_in    = req.dividend[SumW-1] ? (~req.dividend + 1'b1) : req.dividend;
      rem_shift = {rem_ff, quo_ff[SumW-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      rem_diff  = rem_shift - {1'b0, div_ff};
      rem_in    = fits ? rem_diff[LimW-1:0] : rem_shift[LimW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= mag_in;
            div_ff  <= req.divisor;
            neg_ff  <= req.dividend[SumW-1];
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[SumW-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // sign restored on the way out
   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

`default_nettype wire

>>> src/pulse_time_sync_corrector.sv
// top level: disciplines a local millisecond clock against reference time messages
//
//   channel  dir  transfer when        payload
//   req_if   in   valid && ready       action, local_ms, reference_ms
//   rsp_if   out  valid && ready       set_clock, new_time_ms, correction_ms, outcome
//   csr_if   in   valid (ready tied)   index, data
//
// pulse and unmatched sync: from transfer to output register through offset, emit
// in-tolerance and accumulated items: offset, classify, emit
// large step: offset, classify, apply, emit; the shared 45-bit adder forms the offset
//   and then the new time; averaged step: offset, classify, divide, apply, emit,
//   with divide waiting on the 24-step serial divider (one quotient bit per cycle)
// one item in flight; req ready only while the sequencer is idle, the next item can be
//   taken while a result still sits in the output register
// synchronous active-high reset restores thresholds to their defaults and clears
//   pending pulse, miss count and offset sum
`default_nettype none

module pulse_time_sync_corrector (
   input  wire logic   clock,
   input  wire logic   reset,
   ptsc_req_if.sink    req_if,
   ptsc_rsp_if.source  rsp_if,
   ptsc_csr_if.sink    csr_if
);

   localparam int TimeW = ptsc_pkg::TIME_W;
   localparam int CorrW = ptsc_pkg::CORR_W;
   localparam int SumW  = ptsc_pkg::SUM_W;
   localparam int ThrW  = ptsc_pkg::THR_W;
   localparam int LimW  = ptsc_pkg::LIMIT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OFFSET,
      S_CLASSIFY,
      S_DIVIDE,
      S_APPLY,
      S_EMIT
   } state_type;

   state_type                 state_ff;

   // configuration
   logic [ThrW-1:0]           step_thr_ff;
   logic [ThrW-1:0]           tol_ff;
   logic [LimW-1:0]           miss_limit_ff;

   // discipline state
   logic                      pending_ff;
   logic [TimeW-1:0]          capture_ff;
   logic [LimW-1:0]           miss_count_ff;
   logic signed [SumW-1:0]    offset_sum_ff;

   // item being worked on
   logic                      action_ff;
   logic [TimeW-1:0]          local_ff;
   logic [TimeW-1:0]          ref_ff;
   logic signed [CorrW-1:0]   off_ff;

   // finished result, waiting for the output register
   logic                      res_set_ff;
   logic [TimeW-1:0]          res_time_ff;
   logic signed [CorrW-1:0]   res_corr_ff;
   ptsc_pkg::outcome_type     res_outcome_ff;

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_set_ff;
   logic [TimeW-1:0]          rsp_time_ff;
   logic signed [CorrW-1:0]   rsp_corr_ff;
   ptsc_pkg::outcome_type     rsp_outcome_ff;

   ptsc_pkg::div_req_type     div_req_ff;
   ptsc_pkg::div_rsp_type     div_rsp;

   logic                      req_xfer;
   logic                      rsp_xfer;
   logic                      rsp_free;

   // shared adder: reference minus capture, then local plus correction
   logic                      add_sub;
   logic [CorrW-1:0]          add_a;
   logic [CorrW-1:0]          add_b;
   logic [CorrW-1:0]          add_sum;

   logic [CorrW-1:0]          mag_in;
   logic                      over_step;
   logic                      over_tol;
   logic signed [SumW-1:0]    sum_in;
   logic [LimW-1:0]           count_in;
   logic [LimW-1:0]           limit_eff;
   logic                      limit_hit;

   assign req_xfer = req_if.valid && req_if.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   always_comb begin
      add_sub = (state_ff != S_APPLY);
      add_a   = (state_ff == S_APPLY) ? {1'b0, local_ff} : {1'b0, ref_ff};
      add_b   = (state_ff == S_APPLY) ? res_corr_ff : {1'b0, capture_ff};
      add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(CorrW-1){1'b0}}, add_sub};
   end

   always_comb begin
      mag_in    = off_ff[CorrW-1] ? (~off_ff + 1'b1) : off_ff;
      over_step = mag_in > {{(CorrW-ThrW){1'b0}}, step_thr_ff};
      over_tol  = mag_in > {{(CorrW-ThrW){1'b0}}, tol_ff};
      // wraps within the sum width
      sum_in    = offset_sum_ff + off_ff[SumW-1:0];
      count_in  = miss_count_ff + 1'b1;
      // a zero limit behaves as one
      limit_eff = (miss_limit_ff == '0) ? LimW'(1) : miss_limit_ff;
      limit_hit = count_in >= limit_eff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_thr_ff   <= ptsc_pkg::STEP_THR_RESET;
         tol_ff        <= ptsc_pkg::TOLERANCE_RESET;
         miss_limit_ff <= ptsc_pkg::MISS_LIMIT_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            ptsc_pkg::CSR_STEP_THR:   step_thr_ff   <= csr_if.data;
            ptsc_pkg::CSR_TOLERANCE:  tol_ff        <= csr_if.data;
            ptsc_pkg::CSR_MISS_LIMIT: miss_limit_ff <= csr_if.data[LimW-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         pending_ff       <= 1'b0;
         capture_ff       <= '0;
         miss_count_ff    <= '0;
         offset_sum_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         // divider kicked off only on the averaged-step branch of classify
         div_req_ff.start <= (state_ff == S_CLASSIFY) && !over_step && over_tol && limit_hit;

         // output register loads on emit, otherwise empties on a transfer
         if ((state_ff == S_EMIT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  action_ff <= req_if.action;
                  local_ff  <= req_if.local_ms;
                  ref_ff    <= req_if.reference_ms;
                  state_ff  <= S_OFFSET;
               end
            end

            S_OFFSET: begin
               res_set_ff     <= 1'b0;
               res_time_ff    <= '0;
               res_corr_ff    <= '0;
               res_outcome_ff <= ptsc_pkg::OUT_NONE;
               if (!action_ff) begin
                  // pulse: capture overwrites any earlier one
                  capture_ff <= local_ff;
                  pending_ff <= 1'b1;
                  state_ff   <= S_EMIT;
               end else if (!pending_ff) begin
                  // sync with no pulse to match
                  state_ff <= S_EMIT;
               end else begin
                  pending_ff <= 1'b0;
                  off_ff     <= add_sum;
                  state_ff   <= S_CLASSIFY;
               end
            end

            S_CLASSIFY: begin
               if (over_step) begin
                  miss_count_ff  <= '0;
                  offset_sum_ff  <= '0;
                  res_corr_ff    <= off_ff;
                  res_outcome_ff <= ptsc_pkg::OUT_LARGE_STEP;
                  state_ff       <= S_APPLY;
               end else if (over_tol) begin
                  if (limit_hit) begin
                     div_req_ff.dividend <= sum_in;
                     div_req_ff.divisor  <= count_in;
                     miss_count_ff       <= '0;
                     offset_sum_ff       <= '0;
                     res_outcome_ff      <= ptsc_pkg::OUT_AVG_STEP;
                     state_ff            <= S_DIVIDE;
                  end else begin
                     miss_count_ff  <= count_in;
                     offset_sum_ff  <= sum_in;
                     res_outcome_ff <= ptsc_pkg::OUT_ACCUM;
                     state_ff       <= S_EMIT;
                  end
               end else begin
                  miss_count_ff  <= '0;
                  offset_sum_ff  <= '0;
                  res_outcome_ff <= ptsc_pkg::OUT_IN_TOL;
                  state_ff       <= S_EMIT;
               end
            end

            S_DIVIDE: begin
               if (div_rsp.done) begin
                  res_corr_ff <= {{(CorrW-SumW){div_rsp.quotient[SumW-1]}}, div_rsp.quotient};
                  state_ff    <= S_APPLY;
               end
            end

            S_APPLY: begin
               // new time wraps at the clock width
               res_set_ff  <= 1'b1;
               res_time_ff <= add_sum[TimeW-1:0];
               state_ff    <= S_EMIT;
            end

            S_EMIT: begin
               if (rsp_free) begin
                  rsp_set_ff     <= res_set_ff;
                  rsp_time_ff    <= res_time_ff;
                  rsp_corr_ff    <= res_corr_ff;
                  rsp_outcome_ff <= res_outcome_ff;
                  state_ff       <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   ptsc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.set_clock     = rsp_set_ff;
   assign rsp_if.new_time_ms   = rsp_time_ff;
   assign rsp_if.correction_ms = rsp_corr_ff;
   assign rsp_if.outcome       = rsp_outcome_ff;

`ifndef SYNTHESIS
   // no step means no time and no correction
   a_no_step_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.set_clock |->
         rsp_if.new_time_ms == '0 && rsp_if.correction_ms == '0)
      else $error("result without a step carries nonzero time or correction");

   // set_clock exactly for the two stepping outcomes
   a_step_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.set_clock ==
         (rsp_if.outcome == ptsc_pkg::OUT_LARGE_STEP ||
          rsp_if.outcome == ptsc_pkg::OUT_AVG_STEP))
      else $error("set_clock disagrees with outcome");

   // one item at a time
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while an item is in work");

   // quotient only arrives while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIVIDE)
      else $error("divider finished outside the divide step");

   // the stored count always stays below the largest limit
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      miss_count_ff != '1)
      else $error("miss count reached its ceiling");
`endif

endmodule

`default_nettype wire

>>> sim/tb_pulse_time_sync_corrector.sv
// testbench for the pulse time sync corrector: directed table, random traffic, predictor check
`timescale 1ns / 100ps

module tb_pulse_time_sync_corrector;

   localparam logic [ptsc_pkg::TIME_W-1:0] TIME_MAX = '1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;

   // one expected result transfer
   typedef struct packed {
      logic                               set_clock;
      logic [ptsc_pkg::TIME_W-1:0]        new_time_ms;
      logic signed [ptsc_pkg::CORR_W-1:0] correction_ms;
      ptsc_pkg::outcome_type              outcome;
   } correction_type;

   // a row of the directed table; pinned rows carry a result typed in by hand
   typedef struct {
      logic                        act;
      logic [ptsc_pkg::TIME_W-1:0] loc_ms;
      logic [ptsc_pkg::TIME_W-1:0] ref_ms;
      bit                          pinned;
      correction_type              result;
   } stim_row_type;

   // how far the reference lands from the captured pulse time
   typedef enum int {
      OFF_IN_TOL,
      OFF_MODERATE,
      OFF_LARGE,
      OFF_EDGE,
      OFF_WILD
   } offset_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   ptsc_req_if req_ch ();
   ptsc_rsp_if rsp_ch ();
   ptsc_csr_if csr_ch ();

   pulse_time_sync_corrector dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // predictor copy of the registers, reset values from the package
   logic [ptsc_pkg::THR_W-1:0]   cfg_step_thr   = ptsc_pkg::STEP_THR_RESET;
   logic [ptsc_pkg::THR_W-1:0]   cfg_tolerance  = ptsc_pkg::TOLERANCE_RESET;
   logic [ptsc_pkg::LIMIT_W-1:0] cfg_miss_limit = ptsc_pkg::MISS_LIMIT_RESET;

   // predictor copy of the discipline state
   logic                              st_pending    = 1'b0;
   logic [ptsc_pkg::TIME_W-1:0]       st_capture    = '0;
   logic [ptsc_pkg::LIMIT_W-1:0]      st_miss_count = '0;
   logic signed [ptsc_pkg::SUM_W-1:0] st_offset_sum = '0;

   correction_type corrections_due [$];
   stim_row_type   directed_rows [$];

   // pinned expectation travels with the item on the request channel
   bit             pinned_valid  = 1'b0;
   correction_type pinned_result = '0;

   int useful_items    = 0;
   int mismatches      = 0;
   int send_idle_pct   = 0;
   int rsp_idle_pct    = 0;
   int rsp_hold_cycles = 0;
   int quiet_cycles    = 0;

   // work out the correction for one accepted event and advance the state
   function automatic correction_type predict_correction(logic act,
                                                         logic [ptsc_pkg::TIME_W-1:0] loc_ms,
                                                         logic [ptsc_pkg::TIME_W-1:0] ref_ms);
      correction_type                      res;
      logic signed [ptsc_pkg::TIME_W+1:0]  offset;
      logic [ptsc_pkg::TIME_W+1:0]         magnitude;
      logic signed [ptsc_pkg::SUM_W-1:0]   sum_next;
      logic [ptsc_pkg::LIMIT_W-1:0]        count_next;
      logic [ptsc_pkg::LIMIT_W-1:0]        limit;
      int                                  avg;
      res = '0;
      res.outcome = ptsc_pkg::OUT_NONE;
      // pulse: capture and mark pending, a repeated pulse just overwrites
      if (act == 1'b0) begin
         st_capture = loc_ms;
         st_pending = 1'b1;
         useful_items++;
         return res;
      end
      // sync with nothing pending leaves the state alone
      if (!st_pending) return res;
      useful_items++;
      st_pending = 1'b0;
      offset = $signed({2'b00, ref_ms}) - $signed({2'b00, st_capture});
      if (offset < 0) magnitude = -offset;
      else magnitude = offset;
      // the step test comes before the tolerance test
      if (magnitude > cfg_step_thr) begin
         st_miss_count = '0;
         st_offset_sum = '0;
         res.set_clock     = 1'b1;
         res.correction_ms = offset[ptsc_pkg::CORR_W-1:0];
         res.new_time_ms   = loc_ms + offset[ptsc_pkg::TIME_W-1:0];
         res.outcome       = ptsc_pkg::OUT_LARGE_STEP;
      end else if (magnitude > cfg_tolerance) begin
         sum_next   = st_offset_sum + offset[ptsc_pkg::SUM_W-1:0];
         count_next = st_miss_count + 1'b1;
         // a limit of zero behaves like one
         limit = (cfg_miss_limit == '0) ? ptsc_pkg::LIMIT_W'(1) : cfg_miss_limit;
         if (count_next >= limit) begin
            // signed int division truncates toward zero
            avg = int'(sum_next) / int'(count_next);
            st_miss_count = '0;
            st_offset_sum = '0;
            res.set_clock     = 1'b1;
            res.correction_ms = avg;
            res.new_time_ms   = loc_ms + res.correction_ms[ptsc_pkg::TIME_W-1:0];
            res.outcome       = ptsc_pkg::OUT_AVG_STEP;
         end else begin
            st_miss_count = count_next;
            st_offset_sum = sum_next;
            res.outcome   = ptsc_pkg::OUT_ACCUM;
         end
      end else begin
         // in sync: count and sum both start over
         st_miss_count = '0;
         st_offset_sum = '0;
         res.outcome   = ptsc_pkg::OUT_IN_TOL;
      end
      return res;
   endfunction

   function automatic correction_type no_step(ptsc_pkg::outcome_type oc);
      correction_type res;
      res = '0;
      res.outcome = oc;
      return res;
   endfunction

   function automatic correction_type step_to(logic [ptsc_pkg::TIME_W-1:0] new_ms,
                                              logic signed [ptsc_pkg::CORR_W-1:0] corr,
                                              ptsc_pkg::outcome_type oc);
      correction_type res;
      res.set_clock     = 1'b1;
      res.new_time_ms   = new_ms;
      res.correction_ms = corr;
      res.outcome       = oc;
      return res;
   endfunction

   function automatic void add_row(logic act, logic [ptsc_pkg::TIME_W-1:0] loc_ms,
                                   logic [ptsc_pkg::TIME_W-1:0] ref_ms, bit pinned = 1'b0,
                                   correction_type res = '0);
      stim_row_type r;
      r.act    = act;
      r.loc_ms = loc_ms;
      r.ref_ms = ref_ms;
      r.pinned = pinned;
      r.result = res;
      directed_rows.push_back(r);
   endfunction

   // time values: mostly full 44-bit noise, with the ends and small values mixed in
   function automatic logic [ptsc_pkg::TIME_W-1:0] rand_time();
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return TIME_MAX;
         2:       return ptsc_pkg::TIME_W'($urandom_range(100000, 0));
         default: return ptsc_pkg::TIME_W'({$urandom(), $urandom()});
      endcase
   endfunction

   // offset relative to the thresholds currently in force
   function automatic logic signed [ptsc_pkg::TIME_W+1:0] pick_offset(offset_kind_type kind);
      int unsigned                        mag;
      int unsigned                        tol_u;
      int unsigned                        step_u;
      logic signed [ptsc_pkg::TIME_W+1:0] v;
      tol_u  = cfg_tolerance;
      step_u = cfg_step_thr;
      case (kind)
         OFF_IN_TOL:   mag = $urandom_range(tol_u, 0);
         OFF_MODERATE: begin
            if (tol_u < step_u) mag = $urandom_range(step_u, tol_u + 1);
            else mag = $urandom_range(65535, 0);
         end
         OFF_LARGE:    mag = step_u + 1 + $urandom_range(100000, 0);
         default: begin
            // right on either side of each threshold
            case ($urandom_range(3, 0))
               0:       mag = tol_u;
               1:       mag = tol_u + 1;
               2:       mag = step_u;
               default: mag = step_u + 1;
            endcase
         end
      endcase
      v = mag;
      if ($urandom_range(1, 0) != 0) v = -v;
      return v;
   endfunction

   // offer one event, idling first as the current mode asks, and wait for its transfer
   task automatic send_event(logic act, logic [ptsc_pkg::TIME_W-1:0] loc_ms,
                             logic [ptsc_pkg::TIME_W-1:0] ref_ms,
                             bit pinned = 1'b0, correction_type res = '0);
      // idle modes: sender light / receiver heavy, then swapped, then no idling
      if (useful_items < 450) begin
         send_idle_pct = 11;
         rsp_idle_pct  = 72;
      end else if (useful_items < 900) begin
         send_idle_pct = 72;
         rsp_idle_pct  = 11;
      end else begin
         send_idle_pct = 0;
         rsp_idle_pct  = 0;
      end
      while ($urandom_range(99, 0) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.local_ms     <= loc_ms;
      req_ch.reference_ms <= ref_ms;
      pinned_valid        <= pinned;
      pinned_result       <= res;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // a well-formed pulse then sync, with the offset of the given kind
   task automatic send_pair(offset_kind_type kind);
      logic [ptsc_pkg::TIME_W-1:0]        cap;
      logic [ptsc_pkg::TIME_W-1:0]        sync_loc;
      logic [ptsc_pkg::TIME_W-1:0]        ref_ms;
      logic signed [ptsc_pkg::TIME_W+1:0] off;
      logic signed [ptsc_pkg::TIME_W+1:0] target;
      cap = rand_time();
      send_event(1'b0, cap, rand_time());
      if (kind == OFF_WILD) begin
         ref_ms = rand_time();
      end else begin
         off    = pick_offset(kind);
         target = $signed({2'b00, cap}) + off;
         // keep the reference inside the clock range by flipping the sign
         if (target < 0 || target > $signed({2'b00, TIME_MAX}))
            target = $signed({2'b00, cap}) - off;
         ref_ms = target[ptsc_pkg::TIME_W-1:0];
      end
      if ($urandom_range(3, 0) == 0) sync_loc = rand_time();
      else sync_loc = cap + ptsc_pkg::TIME_W'($urandom_range(1500, 0));
      send_event(1'b1, sync_loc, ref_ms);
   endtask

   task automatic random_phase(int count);
      int target;
      int pick;
      target = useful_items + count;
      while (useful_items < target) begin
         pick = $urandom_range(99, 0);
         if (pick < 12) begin
            // noise: lone syncs, lone pulses, anything at all
            case ($urandom_range(2, 0))
               0:       send_event(1'b1, rand_time(), rand_time());
               1:       send_event(1'b0, rand_time(), rand_time());
               default: send_event(1'($urandom_range(1, 0)), rand_time(), rand_time());
            endcase
         end else if (pick < 40) begin
            // a run of moderate offsets, long enough at times to reach any miss limit
            repeat ($urandom_range(16, 1)) send_pair(OFF_MODERATE);
         end else begin
            send_pair(offset_kind_type'($urandom_range(4, 0)));
         end
      end
   endtask

   // stop offering and wait for every expected result
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (corrections_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(ptsc_pkg::csr_index_type idx,
                            logic [ptsc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // registers only change with the block idle
   task automatic apply_setting(logic [ptsc_pkg::THR_W-1:0] step_thr,
                                logic [ptsc_pkg::THR_W-1:0] tol,
                                logic [ptsc_pkg::LIMIT_W-1:0] lim);
      drain();
      csr_write(ptsc_pkg::CSR_STEP_THR, step_thr);
      csr_write(ptsc_pkg::CSR_TOLERANCE, tol);
      csr_write(ptsc_pkg::CSR_MISS_LIMIT, ptsc_pkg::CSR_DATA_W'(lim));
   endtask

   // receiver: random stalls, plus a long hold-off when asked for
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
         end
      end
   end

   // request transfer: predict and queue the expected result
   always @(posedge clock) begin
      correction_type want;
      if (!reset && req_ch.valid && req_ch.ready) begin
         want = predict_correction(req_ch.action, req_ch.local_ms, req_ch.reference_ms);
         if (pinned_valid) want = pinned_result;
         corrections_due.push_back(want);
      end
   end

   // register write transfer: keep the predictor's copy in step
   always @(posedge clock) begin
      if (!reset && csr_ch.valid && csr_ch.ready) begin
         case (ptsc_pkg::csr_index_type'(csr_ch.index))
            ptsc_pkg::CSR_STEP_THR:   cfg_step_thr   = csr_ch.data;
            ptsc_pkg::CSR_TOLERANCE:  cfg_tolerance  = csr_ch.data;
            ptsc_pkg::CSR_MISS_LIMIT: cfg_miss_limit = csr_ch.data[ptsc_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // result transfer: compare field by field with the oldest expectation
   always @(posedge clock) begin
      correction_type got;
      correction_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.set_clock     = rsp_ch.set_clock;
         got.new_time_ms   = rsp_ch.new_time_ms;
         got.correction_ms = rsp_ch.correction_ms;
         got.outcome       = ptsc_pkg::outcome_type'(rsp_ch.outcome);
         if (corrections_due.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected: set=%0b time=%0d corr=%0d outcome=%0d",
                     $time, got.set_clock, got.new_time_ms, got.correction_ms, got.outcome);
         end else begin
            want = corrections_due.pop_front();
            if (got.set_clock !== want.set_clock || got.new_time_ms !== want.new_time_ms ||
                got.correction_ms !== want.correction_ms || got.outcome !== want.outcome) begin
               mismatches++;
               $display("%0t: mismatch expected set=%0b time=%0d corr=%0d outcome=%0d",
                        $time, want.set_clock, want.new_time_ms, want.correction_ms,
                        want.outcome);
               $display("%0t:          actual   set=%0b time=%0d corr=%0d outcome=%0d",
                        $time, got.set_clock, got.new_time_ms, got.correction_ms,
                        got.outcome);
            end
         end
      end
   end

   // watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // every block input known from time zero
      req_ch.valid        = 1'b0;
      req_ch.action       = 1'b0;
      req_ch.local_ms     = '0;
      req_ch.reference_ms = '0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = ptsc_pkg::CSR_STEP_THR;
      csr_ch.data         = '0;

      // directed table, run with the reset settings (step 5000, tolerance 200, limit 5)
      // sync with no pulse pending, all ones in both time fields
      add_row(1'b1, TIME_MAX, TIME_MAX, 1'b1, no_step(ptsc_pkg::OUT_NONE));
      add_row(1'b0, '0, TIME_MAX, 1'b1, no_step(ptsc_pkg::OUT_NONE));
      // pulse while pending overwrites the capture
      add_row(1'b0, 44'd1000, '0, 1'b1, no_step(ptsc_pkg::OUT_NONE));
      // offset exactly at the tolerance is still in sync
      add_row(1'b1, 44'd77, 44'd1200, 1'b1, no_step(ptsc_pkg::OUT_IN_TOL));
      // large step forward
      add_row(1'b0, 44'd2000, '0, 1'b1, no_step(ptsc_pkg::OUT_NONE));
      add_row(1'b1, 44'd2010, 44'd8000, 1'b1,
              step_to(44'd8010, 45'sd6000, ptsc_pkg::OUT_LARGE_STEP));
      // largest negative offset, the new time wraps
      add_row(1'b0, TIME_MAX, '0);
      add_row(1'b1, 44'd5, '0);
      // largest positive offset, the new time wraps
      add_row(1'b0, '0, '0);
      add_row(1'b1, TIME_MAX, TIME_MAX);
      // five moderate offsets of mixed sign end in an averaged step
      add_row(1'b0, 44'd10000, '0);
      add_row(1'b1, 44'd10050, 44'd10300);
      add_row(1'b0, 44'd10000, '0);
      add_row(1'b1, 44'd10050, 44'd10400);
      add_row(1'b0, 44'd10000, '0);
      add_row(1'b1, 44'd10050, 44'd9500);
      add_row(1'b0, 44'd10000, '0);
      add_row(1'b1, 44'd10050, 44'd11000);
      add_row(1'b0, 44'd10000, '0);
      add_row(1'b1, 44'd10050, 44'd10250);
      // offset exactly at the step threshold only accumulates
      add_row(1'b0, 44'd50000, '0);
      add_row(1'b1, 44'd50100, 44'd45000);
      // one past the step threshold steps at once and clears the sum
      add_row(1'b0, 44'd60000, '0);
      add_row(1'b1, 44'd60001, 44'd65001, 1'b1,
              step_to(44'd65002, 45'sd5001, ptsc_pkg::OUT_LARGE_STEP));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_event(directed_rows[i].act, directed_rows[i].loc_ms, directed_rows[i].ref_ms,
                    directed_rows[i].pinned, directed_rows[i].result);

      // sender waits out every result before the random traffic
      drain();

      // long receiver hold-off while events keep coming: the block fills and stalls
      rsp_hold_cycles = 400;
      random_phase(180);

      // widest band: huge step threshold, zero tolerance, largest limit
      apply_setting(16'hFFFF, 16'h0000, 4'd15);
      random_phase(190);
      // tolerance above the threshold, zero limit
      apply_setting(16'h0000, 16'hFFFF, 4'd0);
      random_phase(120);
      // every moderate offset steps by itself
      apply_setting(16'd3000, 16'd300, 4'd1);
      random_phase(190);
      apply_setting(16'd20000, 16'd100, 4'd0);
      random_phase(190);
      apply_setting(16'd1000, 16'd2000, 4'd3);
      random_phase(120);
      apply_setting(ptsc_pkg::THR_W'($urandom_range(65535, 0)),
                    ptsc_pkg::THR_W'($urandom_range(65535, 0)),
                    ptsc_pkg::LIMIT_W'($urandom_range(15, 0)));
      random_phase(160);
      // back to the reset settings
      apply_setting(ptsc_pkg::STEP_THR_RESET, ptsc_pkg::TOLERANCE_RESET,
                    ptsc_pkg::MISS_LIMIT_RESET);
      random_phase(180);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
